### rtl/core/key_debounce_short_long_press_top_macros.svh
// ---------------------------------------------------------------------------
// Key debounce assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while in reset.
// ---------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_SHORT_LONG_PRESS_TOP_MACROS_SVH
`define KEY_DEBOUNCE_SHORT_LONG_PRESS_TOP_MACROS_SVH

// Same-cycle implication
`define KDSLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KDSLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/kdslp_pkg.sv
// ---------------------------------------------------------------------------
// Key debounce package
// Types, register indexes and reset values shared by the key debounce block.
// ---------------------------------------------------------------------------
package kdslp_pkg;

  // Register file
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG_PRESS = 2'd1;

  localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd1500;
  localparam logic [15:0] MS_MAX           = 16'hFFFF;

  // Reported key state codes
  localparam logic [1:0] KS_IDLE     = 2'd0;
  localparam logic [1:0] KS_DEBOUNCE = 2'd1;
  localparam logic [1:0] KS_HELD     = 2'd2;
  localparam logic [1:0] KS_LONG     = 2'd3;

  // Press phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_DEBOUNCE = 4'b0010,
    PH_HELD     = 4'b0100,
    PH_LONG     = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic       short_press;
    logic       long_press;
    logic [1:0] key_state;
  } result_t;

  // Phase to reported code
  function automatic logic [1:0] phase_code(phase_t ph);
    logic [1:0] code;
    unique case (ph)
      PH_DEBOUNCE: code = KS_DEBOUNCE;
      PH_HELD:     code = KS_HELD;
      PH_LONG:     code = KS_LONG;
      default:     code = KS_IDLE;
    endcase
    return code;
  endfunction

endpackage

### rtl/core/kdslp_chan_if.sv
// ---------------------------------------------------------------------------
// Key debounce channels
// Valid/ready channels for key samples and press results.
// ---------------------------------------------------------------------------
interface kdslp_in_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink   (input valid, input key_level, output ready);
endinterface

interface kdslp_out_if;
  logic       valid;
  logic       ready;
  logic       short_press;
  logic       long_press;
  logic [1:0] key_state;

  modport source (output valid, output short_press, output long_press,
                  output key_state, input ready);
  modport sink   (input valid, input short_press, input long_press,
                  input key_state, output ready);
endinterface

### rtl/core/kdslp_cfg_regs.sv
// ---------------------------------------------------------------------------
// Key debounce configuration registers
// Write-only timing registers; writes beyond the list are dropped.
// ---------------------------------------------------------------------------
module kdslp_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [kdslp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kdslp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output kdslp_pkg::cfg_t                     cfg
);

  kdslp_pkg::cfg_t cfg_r;
  kdslp_pkg::cfg_t cfg_nxt;

  // Address decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        kdslp_pkg::CFG_IDX_DEBOUNCE:   cfg_nxt.debounce_ms   = cfg_data;
        kdslp_pkg::CFG_IDX_LONG_PRESS: cfg_nxt.long_press_ms = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= kdslp_pkg::DEBOUNCE_RESET;
      cfg_r.long_press_ms <= kdslp_pkg::LONG_PRESS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/kdslp_in_stage.sv
// ---------------------------------------------------------------------------
// Key debounce input register
// Holds one key sample until the step logic takes it.
// ---------------------------------------------------------------------------
module kdslp_in_stage (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_key,
  output logic in_ready,
  input  logic advance,
  output logic s1_valid,
  output logic s1_key
);

  logic s1_valid_r, s1_valid_nxt;
  logic s1_key_r;
  logic accept;

  // Free when empty or emptying this cycle
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key_r <= in_key;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_key   = s1_key_r;

endmodule

### rtl/core/kdslp_step.sv
// ---------------------------------------------------------------------------
// Key debounce step logic
// Press phase machine and saturating ms counter, updated once per word.
// ---------------------------------------------------------------------------
module kdslp_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kdslp_pkg::cfg_t      cfg,
  input  logic                 advance,
  input  logic                 key,
  output kdslp_pkg::result_t   result
);

  kdslp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]       elapsed_r, elapsed_nxt;
  logic [15:0]       elapsed_inc;
  logic              short_pulse, long_pulse;

  // Saturating tick count
  assign elapsed_inc = (elapsed_r == kdslp_pkg::MS_MAX) ? elapsed_r : elapsed_r + 16'd1;

  // Phase transitions
  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_inc;
    short_pulse = 1'b0;
    long_pulse  = 1'b0;
    unique case (phase_r)
      kdslp_pkg::PH_IDLE: begin
        elapsed_nxt = elapsed_r;
        if (key) begin
          elapsed_nxt = '0;
          phase_nxt   = kdslp_pkg::PH_DEBOUNCE;
        end
      end
      kdslp_pkg::PH_DEBOUNCE: begin
        // key only looked at once the debounce time has passed
        if (elapsed_inc > cfg.debounce_ms) begin
          if (key) begin
            short_pulse = 1'b1;
            phase_nxt   = kdslp_pkg::PH_HELD;
          end else begin
            phase_nxt   = kdslp_pkg::PH_IDLE;
          end
        end
      end
      kdslp_pkg::PH_HELD: begin
        if (!key) begin
          phase_nxt  = kdslp_pkg::PH_IDLE;
        end else if (elapsed_inc > cfg.long_press_ms) begin
          long_pulse = 1'b1;
          phase_nxt  = kdslp_pkg::PH_LONG;
        end
      end
      kdslp_pkg::PH_LONG: begin
        if (!key) begin
          phase_nxt = kdslp_pkg::PH_IDLE;
        end
      end
      default: begin
        elapsed_nxt = elapsed_r;
        phase_nxt   = kdslp_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= kdslp_pkg::PH_IDLE;
      elapsed_r <= '0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  assign result.short_press = short_pulse;
  assign result.long_press  = long_pulse;
  assign result.key_state   = kdslp_pkg::phase_code(phase_nxt);

endmodule

### rtl/core/kdslp_out_stage.sv
// ---------------------------------------------------------------------------
// Key debounce result register
// Holds one result word until the sink takes it.
// ---------------------------------------------------------------------------
module kdslp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  input  kdslp_pkg::result_t result,
  output logic               advance,
  input  logic               out_ready,
  output logic               out_valid,
  output kdslp_pkg::result_t out_result
);

  logic               out_valid_r, out_valid_nxt;
  kdslp_pkg::result_t out_result_r;
  logic               free;

  // Room when empty or the sink takes the word now
  assign free    = !out_valid_r || out_ready;
  assign advance = s1_valid && free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result_r <= result;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

### rtl/core/key_debounce_short_long_press_top.sv
// ---------------------------------------------------------------------------
// Key debounce with short and long press detection
// One key sample per ms tick in, one press result word out per sample.
// ---------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_chan   in   valid/ready    key_level
//  out_chan  out  valid/ready    short_press, long_press, key_state[1:0]
//  cfg_*     in   cfg_we         cfg_index[1:0], cfg_data[15:0]
//
// One word per cycle while the sink is ready; a word passes the input
// and result registers, phase machine and ms counter updating as it moves.
// Reset (rst_n low, synchronous) clears both stages, the phase to idle, the
// counter to zero and the registers to 50 and 1500 ms.
// A stalled sink holds the result word; one more sample waits in the input
// register before in_chan.ready drops.
// ---------------------------------------------------------------------------
`include "key_debounce_short_long_press_top_macros.svh"

module key_debounce_short_long_press_top (
  input  logic                             clk,
  input  logic                             rst_n,
  kdslp_in_if.sink                         in_chan,
  kdslp_out_if.source                      out_chan,
  input  logic                             cfg_we,
  input  logic [kdslp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdslp_pkg::CFG_DATA_W-1:0] cfg_data
);

  kdslp_pkg::cfg_t    cfg;
  kdslp_pkg::result_t result;
  kdslp_pkg::result_t out_result;
  logic               advance;
  logic               s1_valid;
  logic               s1_key;
  logic               in_ready;
  logic               out_valid;

  // Timing registers
  kdslp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  kdslp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_key   (in_chan.key_level),
    .in_ready (in_ready),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_key   (s1_key)
  );

  // Phase machine
  kdslp_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .advance (advance),
    .key     (s1_key),
    .result  (result)
  );

  // Result register
  kdslp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .result     (result),
    .advance    (advance),
    .out_ready  (out_chan.ready),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid;
  assign out_chan.short_press = out_result.short_press;
  assign out_chan.long_press  = out_result.long_press;
  assign out_chan.key_state   = out_result.key_state;

  // Checks
  `KDSLP_ASSERT_IMP(a_one_pulse, out_valid,
    !(out_result.short_press && out_result.long_press),
    "short and long press in one word")
  `KDSLP_ASSERT_IMP(a_short_held, out_valid && out_result.short_press,
    out_result.key_state == kdslp_pkg::KS_HELD,
    "short press outside held state")
  `KDSLP_ASSERT_IMP(a_long_state, out_valid && out_result.long_press,
    out_result.key_state == kdslp_pkg::KS_LONG,
    "long press outside long held state")
  `KDSLP_ASSERT_IMP(a_full_stall, s1_valid && out_valid && !out_chan.ready,
    !in_ready && !advance,
    "word taken while both stages are full and stalled")

endmodule
